// ----- rtl/trdf_pkg.sv -----
// ----------------------------------------------------------------------------
// trdf_pkg
// Types and constants shared by the touch report decode and filter block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package trdf_pkg;

  localparam int COORD_W   = 12;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 3;
  localparam int CNT_SAT_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLIP_X        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FLIP_Y        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EXCHANGE_AXES = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_JUMP_LIMIT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_MIN   = 3'd6;

  localparam logic [1:0] EV_DOWN    = 2'd0;
  localparam logic [1:0] EV_CONTACT = 2'd2;

  localparam logic KIND_SLOT = 1'b0;
  localparam logic KIND_SYNC = 1'b1;

  localparam logic [CNT_SAT_W-1:0] SAMPLES_MAX = 3'd7;

  typedef struct packed {
    logic [7:0] count_byte;
    logic [7:0] p0_xh;
    logic [7:0] p0_xl;
    logic [7:0] p0_yh;
    logic [7:0] p0_yl;
    logic [7:0] p1_xh;
    logic [7:0] p1_xl;
    logic [7:0] p1_yh;
    logic [7:0] p1_yl;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic [3:0]         slot_id;
    logic               active;
    logic               has_position;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [7:0] xh;
    logic [7:0] xl;
    logic [7:0] yh;
    logic [7:0] yl;
  } point_raw_t;

  typedef struct packed {
    logic [COORD_W-1:0]   size_x;
    logic [COORD_W-1:0]   size_y;
    logic                 flip_x;
    logic                 flip_y;
    logic                 exchange_axes;
    logic [COORD_W-1:0]   jump_limit;
    logic [CNT_SAT_W-1:0] release_min_samples;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] last_x;
    logic [COORD_W-1:0] last_y;
    logic               older_valid;
  } filt_state_t;

  localparam out_item_t SYNC_ITEM = '{
    kind: KIND_SYNC, slot_id: 4'd0, active: 1'b0, has_position: 1'b0,
    pos_x: '0, pos_y: '0, last: 1'b1
  };

endpackage

// ----- rtl/touch_report_decode_filter.sv -----
// ----------------------------------------------------------------------------
// touch_report_decode_filter
// Decodes raw touch frames into slot reports and frame syncs, with a
// per-point jitter filter.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one raw frame per item (valid/ready). Accepted when in_valid and
//           in_ready are both high.
//   out_* : result items (valid/ready), one per cycle while out_ready is
//           high: a slot report for each decoded point, then a frame sync
//           with last set. A zero-count frame gives one sync or nothing.
//   cfg_* : write port for the seven settings; write only while idle.
// Flow: an accepted frame is held in the input register, then loaded into
//   the result buffer, from which its first result is offered. The single
//   output port draining the result buffer sets the frame rate; the next
//   frame loads as the last result of the previous one is taken.
// Reset: filter state and sample count clear, settings return to defaults,
//   no results pending.
// Stall: a stalled output holds the buffer; one more frame waits in the input
//   register, then in_ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module touch_report_decode_filter #(
  parameter int MAX_POINTS = 2
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  trdf_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output trdf_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [trdf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [trdf_pkg::CFG_W-1:0]          cfg_data
);
  import trdf_pkg::*;

  localparam int DEPTH = MAX_POINTS + 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cfg_t        cfg_r;
  in_item_t    in_r;
  logic        in_vld_r;
  logic        adv, can_load;

  filt_state_t          st_r   [MAX_POINTS];
  filt_state_t          st_nxt [MAX_POINTS];
  filt_state_t          st_upd [MAX_POINTS];
  point_raw_t           raw    [2];
  out_item_t            rpt    [MAX_POINTS];
  logic [MAX_POINTS-1:0] en, act;

  logic [CNT_SAT_W-1:0] samples_r, samples_nxt;
  logic [CNT_SAT_W:0]   samples_sum;
  logic                 zero_cnt;
  logic [CNT_W-1:0]     n_cnt, load_cnt;
  out_item_t            items [DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.size_x              <= 12'd4095;
      cfg_r.size_y              <= 12'd4095;
      cfg_r.flip_x              <= 1'b1;
      cfg_r.flip_y              <= 1'b0;
      cfg_r.exchange_axes       <= 1'b1;
      cfg_r.jump_limit          <= 12'd8;
      cfg_r.release_min_samples <= 3'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SIZE_X:        cfg_r.size_x              <= cfg_data;
        CFG_SIZE_Y:        cfg_r.size_y              <= cfg_data;
        CFG_FLIP_X:        cfg_r.flip_x              <= cfg_data[0];
        CFG_FLIP_Y:        cfg_r.flip_y              <= cfg_data[0];
        CFG_EXCHANGE_AXES: cfg_r.exchange_axes       <= cfg_data[0];
        CFG_JUMP_LIMIT:    cfg_r.jump_limit          <= cfg_data;
        CFG_RELEASE_MIN:   cfg_r.release_min_samples <= cfg_data[CNT_SAT_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv      = in_vld_r && can_load;
  assign in_ready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_data;
    end
  end

  assign raw[0]   = '{xh: in_r.p0_xh, xl: in_r.p0_xl, yh: in_r.p0_yh, yl: in_r.p0_yl};
  assign raw[1]   = '{xh: in_r.p1_xh, xl: in_r.p1_xl, yh: in_r.p1_yh, yl: in_r.p1_yl};
  assign zero_cnt = (in_r.count_byte[3:0] == 4'd0);

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_point
    assign en[i] = (in_r.count_byte[3:0] > 4'(i));

    trdf_point u_point (
      .en      (en[i]),
      .raw     (raw[i]),
      .cfg     (cfg_r),
      .st      (st_r[i]),
      .st_nxt  (st_upd[i]),
      .report  (rpt[i]),
      .act_cnt (act[i])
    );
  end

  always_comb begin
    n_cnt       = '0;
    samples_sum = {1'b0, samples_r};
    for (int i = 0; i < MAX_POINTS; i++) begin
      n_cnt       = n_cnt + CNT_W'(en[i]);
      samples_sum = samples_sum + (CNT_SAT_W+1)'(act[i]);
    end

    if (zero_cnt) begin
      load_cnt    = CNT_W'(samples_r > cfg_r.release_min_samples);
      samples_nxt = '0;
    end else begin
      load_cnt    = n_cnt + CNT_W'(1);
      samples_nxt = (samples_sum > (CNT_SAT_W+1)'(SAMPLES_MAX)) ?
                    SAMPLES_MAX : samples_sum[CNT_SAT_W-1:0];
    end

    for (int i = 0; i < MAX_POINTS; i++) begin
      st_nxt[i] = zero_cnt ? filt_state_t'('0) : st_upd[i];
    end

    // reports first, then the frame sync
    for (int k = 0; k < DEPTH; k++) begin
      items[k] = SYNC_ITEM;
    end
    for (int k = 0; k < MAX_POINTS; k++) begin
      if (!zero_cnt && (CNT_W'(k) < n_cnt)) begin
        items[k] = rpt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      samples_r <= '0;
      for (int i = 0; i < MAX_POINTS; i++) begin
        st_r[i] <= '0;
      end
    end else if (adv) begin
      samples_r <= samples_nxt;
      st_r      <= st_nxt;
    end
  end

  trdf_res_buf #(
    .DEPTH (DEPTH)
  ) u_res_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (adv),
    .load_items (items),
    .load_cnt   (load_cnt),
    .can_load   (can_load),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// ----- rtl/trdf_point.sv -----
// ----------------------------------------------------------------------------
// trdf_point
// One point lane: decode, invert and swap, and the jitter filter update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trdf_point (
  input  logic                 en,
  input  trdf_pkg::point_raw_t raw,
  input  trdf_pkg::cfg_t       cfg,
  input  trdf_pkg::filt_state_t st,
  output trdf_pkg::filt_state_t st_nxt,
  output trdf_pkg::out_item_t  report,
  output logic                 act_cnt
);
  import trdf_pkg::*;

  logic [COORD_W-1:0] x_raw, y_raw, x_inv, y_inv, nx, ny, dx, dy;
  logic [1:0]         ev;
  logic [3:0]         id;
  logic               act, empty, jump, rel;

  always_comb begin
    x_raw = {raw.xh[3:0], raw.xl};
    y_raw = {raw.yh[3:0], raw.yl};
    ev    = raw.xh[7:6];
    id    = raw.yh[7:4];
    act   = ev inside {EV_DOWN, EV_CONTACT};

    x_inv = x_raw;
    if (cfg.flip_x) begin
      x_inv = (cfg.size_x >= x_raw) ? cfg.size_x - x_raw : '0;
    end
    y_inv = y_raw;
    if (cfg.flip_y) begin
      y_inv = (cfg.size_y >= y_raw) ? cfg.size_y - y_raw : '0;
    end
    if (cfg.exchange_axes) begin
      nx = y_inv;
      ny = x_inv;
    end else begin
      nx = x_inv;
      ny = y_inv;
    end

    dx    = (st.last_x > nx) ? st.last_x - nx : nx - st.last_x;
    dy    = (st.last_y > ny) ? st.last_y - ny : ny - st.last_y;
    empty = (st.last_x == '0) && (st.last_y == '0);
    jump  = (dx > cfg.jump_limit) || (dy > cfg.jump_limit);

    st_nxt = st;
    rel    = 1'b0;
    if (en && act) begin
      if (empty) begin
        st_nxt.last_x = nx;
        st_nxt.last_y = ny;
      end else if (jump) begin
        st_nxt.last_x = '0;
        st_nxt.last_y = '0;
      end else begin
        rel                = st.older_valid;
        st_nxt.older_valid = (st.last_x != '0) && (st.last_y != '0);
        st_nxt.last_x      = nx;
        st_nxt.last_y      = ny;
      end
    end

    report.kind         = KIND_SLOT;
    report.slot_id      = id;
    report.active       = act;
    report.has_position = rel;
    report.pos_x        = rel ? nx : '0;
    report.pos_y        = rel ? ny : '0;
    report.last         = 1'b0;

    act_cnt = en && act;
  end

endmodule

// ----- rtl/trdf_res_buf.sv -----
// ----------------------------------------------------------------------------
// trdf_res_buf
// Result buffer: loads one frame's items, hands one out each cycle out_ready is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trdf_res_buf #(
  parameter int DEPTH = 3
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  trdf_pkg::out_item_t         load_items [DEPTH],
  input  logic [$clog2(DEPTH+1)-1:0]  load_cnt,
  output logic                        can_load,
  output logic                        out_valid,
  input  logic                        out_ready,
  output trdf_pkg::out_item_t         out_data
);
  import trdf_pkg::*;

  localparam int CNT_W = $clog2(DEPTH+1);

  out_item_t        buf_r [DEPTH];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = buf_r[0];
  assign pop       = out_valid && out_ready;
  assign can_load  = (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && pop);

  always_comb begin
    cnt_nxt = cnt_r;
    if (load) begin
      cnt_nxt = load_cnt;
    end else if (pop) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // advance the queue on pop, replace it on load
  always_ff @(posedge clk) begin
    if (load) begin
      buf_r <= load_items;
    end else if (pop) begin
      for (int k = 0; k < DEPTH - 1; k++) begin
        buf_r[k] <= buf_r[k+1];
      end
    end
  end

endmodule

// ----- tb/touch_report_decode_filter_tb.sv -----
// ----------------------------------------------------------------------------
// touch_report_decode_filter_tb
// Self-checking bench for the touch frame decoder and jitter filter. A table
// of directed frames runs first, then setting phases of random touch gestures
// mixed with noise frames, under varied sender and receiver pacing. Every
// result item is compared field by field with typed values or a behavioral model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module touch_report_decode_filter_tb;
  import trdf_pkg::*;

  localparam int          MAX_PTS         = 2;
  localparam int          HALF_PERIOD     = 6;
  localparam int          LIMIT_CYCLES    = 200000;
  localparam int          SETTLE_CYCLES   = 6;
  localparam int          N_PHASES        = 8;
  localparam int          ITEMS_PER_PHASE = 20;
  localparam int          PREDICTED       = -1;
  localparam logic [1:0]  EV_UP           = 2'd1;
  localparam logic [1:0]  EV_NONE         = 2'd3;

  typedef struct {
    in_item_t          frame;
    int                n_typed;
    out_item_t [2:0]   typed;
  } frame_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  in_item_t               in_data;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_item_t              out_data;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]       cfg_data;

  cfg_t                   model_cfg;
  logic [COORD_W-1:0]     hist_x [MAX_PTS];
  logic [COORD_W-1:0]     hist_y [MAX_PTS];
  bit                     hist_old [MAX_PTS];
  logic [CNT_SAT_W-1:0]   samples;

  out_item_t              expected_reports [$];
  frame_row_t             frame_table [$];
  int unsigned            err_count = 0;
  int unsigned            cycle_count = 0;
  int unsigned            snd_idle_pct = 0;
  int unsigned            rcv_stall_pct = 0;

  int                     touch_left = 0;
  int                     touch_pts = 1;
  logic [COORD_W-1:0]     touch_x [MAX_PTS];
  logic [COORD_W-1:0]     touch_y [MAX_PTS];
  logic [3:0]             touch_id [MAX_PTS];

  touch_report_decode_filter #(
    .MAX_POINTS(MAX_PTS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    err_count++;
    if (err_count <= 50)
      $display("mismatch: %s expected %0h got %0h (cycle %0d)", what, want, got, cycle_count);
  endtask

  function automatic logic [COORD_W-1:0] coord_gap(logic [COORD_W-1:0] a,
                                                   logic [COORD_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [COORD_W-1:0] clamp_coord(int v);
    return (v < 0) ? 12'd0 : ((v > 4095) ? 12'd4095 : 12'(v));
  endfunction

  function automatic point_raw_t mk_point(logic [1:0] ev, logic [3:0] id,
                                          logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    return {ev, 2'b00, x[11:8], x[7:0], id, y[11:8], y[7:0]};
  endfunction

  function automatic out_item_t mk_slot(logic [3:0] id, logic act);
    return '{kind: KIND_SLOT, slot_id: id, active: act, has_position: 1'b0,
             pos_x: 12'd0, pos_y: 12'd0, last: 1'b0};
  endfunction

  // decode one frame, advance the filter state, return the result items
  function automatic int decode_and_filter(in_item_t f, output out_item_t [2:0] res);
    point_raw_t          pts [MAX_PTS];
    int                  npts;
    int                  k;
    logic [COORD_W-1:0]  x, y, nx, ny;
    logic [1:0]          ev;
    logic [3:0]          id;
    bit                  act, rel;
    pts[0] = {f.p0_xh, f.p0_xl, f.p0_yh, f.p0_yl};
    pts[1] = {f.p1_xh, f.p1_xl, f.p1_yh, f.p1_yl};
    res = '0;
    k = 0;
    npts = int'(f.count_byte[3:0]);
    if (npts == 0) begin
      for (int i = 0; i < MAX_PTS; i++) begin
        hist_x[i] = '0;
        hist_y[i] = '0;
        hist_old[i] = 1'b0;
      end
      if (samples > model_cfg.release_min_samples) begin
        res[0] = SYNC_ITEM;
        k = 1;
      end
      samples = '0;
      return k;
    end
    if (npts > MAX_PTS) npts = MAX_PTS;
    for (int i = 0; i < npts; i++) begin
      x = {pts[i].xh[3:0], pts[i].xl};
      y = {pts[i].yh[3:0], pts[i].yl};
      ev = pts[i].xh[7:6];
      id = pts[i].yh[7:4];
      act = (ev == EV_DOWN) || (ev == EV_CONTACT);
      rel = 1'b0;
      nx = '0;
      ny = '0;
      if (act) begin
        if (samples != SAMPLES_MAX) samples++;
        if (model_cfg.flip_x) x = (model_cfg.size_x >= x) ? model_cfg.size_x - x : 12'd0;
        if (model_cfg.flip_y) y = (model_cfg.size_y >= y) ? model_cfg.size_y - y : 12'd0;
        if (model_cfg.exchange_axes) begin
          nx = y;
          ny = x;
        end else begin
          nx = x;
          ny = y;
        end
        if (hist_x[i] == 0 && hist_y[i] == 0) begin
          hist_x[i] = nx;
          hist_y[i] = ny;
        end else if (coord_gap(hist_x[i], nx) > model_cfg.jump_limit ||
                     coord_gap(hist_y[i], ny) > model_cfg.jump_limit) begin
          hist_x[i] = '0;
          hist_y[i] = '0;
        end else begin
          rel = hist_old[i];
          hist_old[i] = (hist_x[i] != 0) && (hist_y[i] != 0);
          hist_x[i] = nx;
          hist_y[i] = ny;
        end
      end
      res[k] = '{kind: KIND_SLOT, slot_id: id, active: act, has_position: rel,
                 pos_x: rel ? nx : 12'd0, pos_y: rel ? ny : 12'd0, last: 1'b0};
      k++;
    end
    res[k] = SYNC_ITEM;
    k++;
    return k;
  endfunction

  // mostly well-formed gestures: a run of frames with small drift, then a lift
  function automatic in_item_t random_frame();
    logic [95:0] noise;
    logic [7:0]  cnt;
    logic [1:0]  ev;
    point_raw_t  p [MAX_PTS];
    int          span;
    noise = {$urandom, $urandom, $urandom};
    if ($urandom_range(9) == 0) return noise[71:0];
    if (touch_left == 0) begin
      touch_left = $urandom_range(12, 3);
      touch_pts = $urandom_range(2, 1);
      for (int i = 0; i < MAX_PTS; i++) begin
        touch_x[i] = 12'($urandom_range(4095, 1));
        touch_y[i] = 12'($urandom_range(4095, 1));
        touch_id[i] = 4'($urandom_range(15));
      end
    end
    touch_left--;
    if (touch_left == 0) return {4'($urandom_range(15)), 4'h0, noise[63:0]};
    span = (model_cfg.jump_limit < 16) ? int'(model_cfg.jump_limit) + 1 : 16;
    for (int i = 0; i < MAX_PTS; i++) begin
      if ($urandom_range(11) == 0) begin
        touch_x[i] = 12'($urandom_range(4095));
        touch_y[i] = 12'($urandom_range(4095));
      end else begin
        touch_x[i] = clamp_coord(int'(touch_x[i]) + int'($urandom_range(2 * span)) - span);
        touch_y[i] = clamp_coord(int'(touch_y[i]) + int'($urandom_range(2 * span)) - span);
      end
      ev = ($urandom_range(7) == 0) ? {1'($urandom_range(1)), 1'b1}
                                    : {1'($urandom_range(1)), 1'b0};
      p[i] = {ev, 2'($urandom_range(3)), touch_x[i][11:8], touch_x[i][7:0],
              touch_id[i], touch_y[i][11:8], touch_y[i][7:0]};
    end
    cnt = {4'($urandom_range(15)), 4'(touch_pts)};
    if (touch_pts == 2 && $urandom_range(7) == 0) cnt[3:0] = 4'($urandom_range(15, 3));
    return {cnt, p[0], p[1]};
  endfunction

  task automatic add_row(in_item_t f, int n, out_item_t r0 = '0, out_item_t r1 = '0,
                         out_item_t r2 = '0);
    frame_row_t row;
    row.frame = f;
    row.n_typed = n;
    row.typed = {r2, r1, r0};
    frame_table.push_back(row);
  endtask

  task automatic send_frame(in_item_t f, int n_typed, out_item_t [2:0] typed);
    out_item_t [2:0] res;
    int              n;
    @(negedge clk);
    if ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= f;
    do @(posedge clk); while (!in_ready);
    n = decode_and_filter(f, res);
    if (n_typed != PREDICTED) begin
      for (int i = 0; i < n_typed; i++) expected_reports.push_back(typed[i]);
    end else begin
      for (int i = 0; i < n; i++) expected_reports.push_back(res[i]);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_SIZE_X:        model_cfg.size_x = val;
      CFG_SIZE_Y:        model_cfg.size_y = val;
      CFG_FLIP_X:        model_cfg.flip_x = val[0];
      CFG_FLIP_Y:        model_cfg.flip_y = val[0];
      CFG_EXCHANGE_AXES: model_cfg.exchange_axes = val[0];
      CFG_JUMP_LIMIT:    model_cfg.jump_limit = val;
      CFG_RELEASE_MIN:   model_cfg.release_min_samples = val[CNT_SAT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_cfg(cfg_t c);
    write_reg(CFG_SIZE_X, c.size_x);
    write_reg(CFG_SIZE_Y, c.size_y);
    write_reg(CFG_FLIP_X, c.flip_x);
    write_reg(CFG_FLIP_Y, c.flip_y);
    write_reg(CFG_EXCHANGE_AXES, c.exchange_axes);
    write_reg(CFG_JUMP_LIMIT, c.jump_limit);
    write_reg(CFG_RELEASE_MIN, c.release_min_samples);
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk) in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(negedge clk) out_ready <= ($urandom_range(99) >= rcv_stall_pct);

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        report_mismatch("result with nothing expected", '0, out_data);
      end else begin
        want = expected_reports.pop_front();
        if (out_data.kind !== want.kind)
          report_mismatch("kind", want.kind, out_data.kind);
        if (out_data.slot_id !== want.slot_id)
          report_mismatch("slot_id", want.slot_id, out_data.slot_id);
        if (out_data.active !== want.active)
          report_mismatch("active", want.active, out_data.active);
        if (out_data.has_position !== want.has_position)
          report_mismatch("has_position", want.has_position, out_data.has_position);
        if (out_data.pos_x !== want.pos_x)
          report_mismatch("pos_x", want.pos_x, out_data.pos_x);
        if (out_data.pos_y !== want.pos_y)
          report_mismatch("pos_y", want.pos_y, out_data.pos_y);
        if (out_data.last !== want.last)
          report_mismatch("last", want.last, out_data.last);
      end
    end
  end

  initial begin : stimulus
    cfg_t setting;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    model_cfg = '{size_x: 12'd4095, size_y: 12'd4095, flip_x: 1'b1, flip_y: 1'b0,
                  exchange_axes: 1'b1, jump_limit: 12'd8, release_min_samples: 3'd3};
    samples = '0;
    for (int i = 0; i < MAX_PTS; i++) begin
      hist_x[i] = '0;
      hist_y[i] = '0;
      hist_old[i] = 1'b0;
    end

    add_row({8'h00, mk_point(EV_DOWN, 4'h1, 12'd10, 12'd10), 32'h0}, 0);
    add_row({8'h02, mk_point(EV_UP, 4'hF, 12'hFFF, 12'hFFF),
             mk_point(EV_NONE, 4'h0, 12'h000, 12'h000)},
            3, mk_slot(4'hF, 1'b0), mk_slot(4'h0, 1'b0), SYNC_ITEM);
    add_row({8'h01, mk_point(EV_DOWN, 4'h3, 12'd100, 12'd200), 32'hFFFF_FFFF},
            2, mk_slot(4'h3, 1'b1), SYNC_ITEM);
    add_row({8'h01, mk_point(EV_CONTACT, 4'h3, 12'd103, 12'd205), 32'h0}, PREDICTED);
    add_row({8'h01, mk_point(EV_CONTACT, 4'h3, 12'd105, 12'd201), 32'h0}, PREDICTED);
    add_row({8'h02, mk_point(EV_CONTACT, 4'h3, 12'd107, 12'd199),
             mk_point(EV_DOWN, 4'h5, 12'd4095, 12'd1)}, PREDICTED);
    add_row({8'h0F, mk_point(EV_CONTACT, 4'h3, 12'd300, 12'd199),
             mk_point(EV_CONTACT, 4'h5, 12'd4095, 12'd3)}, PREDICTED);
    add_row({8'h32, mk_point(EV_CONTACT, 4'h3, 12'd300, 12'd199),
             mk_point(EV_CONTACT, 4'h5, 12'd4090, 12'd4)}, PREDICTED);
    add_row({8'h00, 32'hA5A5_5A5A, 32'h5A5A_A5A5}, 1, SYNC_ITEM);
    add_row({8'hF0, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 0);
    add_row({8'h01, mk_point(EV_DOWN, 4'h1, 12'd50, 12'd60), 32'h0}, PREDICTED);
    add_row({8'h01, mk_point(EV_CONTACT, 4'h1, 12'd50, 12'd60), 32'h0}, PREDICTED);
    add_row({8'h01, mk_point(EV_CONTACT, 4'h1, 12'd50, 12'd60), 32'h0}, PREDICTED);
    add_row({8'h00, 32'h0, 32'h0}, 0);
    add_row({8'h02, mk_point(EV_DOWN, 4'h2, 12'd500, 12'd500),
             mk_point(EV_DOWN, 4'h7, 12'd900, 12'd900)}, PREDICTED);
    add_row({8'h02, mk_point(EV_CONTACT, 4'h2, 12'd500, 12'd509),
             mk_point(EV_CONTACT, 4'h7, 12'd909, 12'd900)}, PREDICTED);
    add_row({8'h02, mk_point(EV_CONTACT, 4'h2, 12'd500, 12'd508),
             mk_point(EV_CONTACT, 4'h7, 12'd900, 12'd908)}, PREDICTED);
    add_row({8'h02, mk_point(EV_CONTACT, 4'h2, 12'd501, 12'd507),
             mk_point(EV_CONTACT, 4'h7, 12'd901, 12'd907)}, PREDICTED);
    add_row({8'h01, mk_point(EV_NONE, 4'h9, 12'd77, 12'd88), 32'h0},
            2, mk_slot(4'h9, 1'b0), SYNC_ITEM);
    add_row({8'h00, 32'h0, 32'h0}, PREDICTED);

    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    foreach (frame_table[r])
      send_frame(frame_table[r].frame, frame_table[r].n_typed, frame_table[r].typed);
    wait_idle();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: setting = '{size_x: 12'd4095, size_y: 12'd4095, flip_x: 1'b1, flip_y: 1'b0,
                       exchange_axes: 1'b1, jump_limit: 12'd8, release_min_samples: 3'd3};
        1: setting = '{size_x: 12'd0, size_y: 12'd0, flip_x: 1'b1, flip_y: 1'b1,
                       exchange_axes: 1'b0, jump_limit: 12'd4095, release_min_samples: 3'd0};
        2: setting = '{size_x: 12'd4095, size_y: 12'd4095, flip_x: 1'b0, flip_y: 1'b0,
                       exchange_axes: 1'b0, jump_limit: 12'd0, release_min_samples: 3'd7};
        3: setting = '{size_x: 12'($urandom_range(600)), size_y: 12'($urandom_range(600)),
                       flip_x: 1'b1, flip_y: 1'b1, exchange_axes: 1'b1, jump_limit: 12'd3,
                       release_min_samples: 3'($urandom_range(7))};
        default: begin
          setting.size_x = 12'($urandom_range(4095));
          setting.size_y = 12'($urandom_range(4095));
          setting.flip_x = 1'($urandom_range(1));
          setting.flip_y = 1'($urandom_range(1));
          setting.exchange_axes = 1'($urandom_range(1));
          setting.jump_limit = ($urandom_range(4) == 0) ? 12'd4095 : 12'($urandom_range(24));
          setting.release_min_samples = 3'($urandom_range(7));
        end
      endcase
      apply_cfg(setting);
      case (ph % 4)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 55; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 55; end
        default: begin snd_idle_pct = 26; rcv_stall_pct = 26; end
      endcase
      repeat (ITEMS_PER_PHASE) send_frame(random_frame(), PREDICTED, '0);
      wait_idle();
    end

    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
